/* sv/mbrc_pkg.sv */
`timescale 1ns / 1ps

package mbrc_pkg;

   // Longest response frame accepted, in bytes (byte count + 5)
   localparam int unsigned MAX_FRAME_BYTES = 256;

   localparam int unsigned POS_WIDTH = 9;
   localparam int unsigned CSR_INDEX_WIDTH = 1;

   typedef enum logic [2:0] {
      ST_FLOAT_OK     = 3'd0,
      ST_UINT_OK      = 3'd1,
      ST_BAD_ADDRESS  = 3'd2,
      ST_BAD_FUNCTION = 3'd3,
      ST_CRC_MISMATCH = 3'd4,
      ST_NO_DATA      = 3'd5,
      ST_TOO_LONG     = 3'd6
   } status_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MIN_SLAVE_ADDRESS = 1'b0,
      CSR_MAX_SLAVE_ADDRESS = 1'b1
   } csr_index_type;

   localparam logic [7:0] FC_READ_HOLDING   = 8'd3;
   localparam logic [7:0] FC_WRITE_SINGLE   = 8'd6;
   localparam logic [7:0] FC_WRITE_MULTIPLE = 8'd16;

   localparam logic [POS_WIDTH-1:0] LEN_OVERHEAD = 9'd5;
   localparam logic [POS_WIDTH-1:0] LEN_UINT     = 9'd7;
   localparam logic [POS_WIDTH-1:0] LEN_FLOAT    = 9'd9;

   localparam logic [POS_WIDTH-1:0] POS_ADDRESS  = 9'd0;
   localparam logic [POS_WIDTH-1:0] POS_FUNCTION = 9'd1;
   localparam logic [POS_WIDTH-1:0] POS_COUNT    = 9'd2;
   localparam logic [POS_WIDTH-1:0] POS_LAST_DATA = 9'd6;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // CRC-16/MODBUS, one byte, reflected polynomial
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* sv/modbus_rtu_response_checker_top.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  rx_byte[7:0], frame_start
// rsp_      out        rsp_valid/rsp_stall  status[2:0], function_code[7:0],
//                                           data_value[31:0]
// csr_      in         csr_write_enable     csr_index[0], csr_write_data[7:0]
//
// One request per cycle while req_stall is low. A request is held in the input
// register, then the frame logic (byte-wide CRC update, compares) runs and
// a result, if any, lands in the output register.
// Reset (synchronous) drops any partial frame and loads the address range
// 1..247. A stalled result holds the output register; the input register
// still takes a request, and req_stall rises only when both are full.

module modbus_rtu_response_checker_top
   import mbrc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,

   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_rx_byte,
   input  logic                       req_frame_start,

   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_status,
   output logic [7:0]                 rsp_function_code,
   output logic [31:0]                rsp_data_value,

   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                 csr_write_data
);

   // configuration
   logic [7:0]  min_addr_ff, min_addr_in;
   logic [7:0]  max_addr_ff, max_addr_in;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;

   // frame state
   logic                 active_ff,   active_in;
   logic [POS_WIDTH-1:0] pos_ff,      pos_in;
   logic [POS_WIDTH-1:0] len_ff,      len_in;
   logic [7:0]           func_ff,     func_in;
   logic [15:0]          crc_ff,      crc_in;
   logic [7:0]           crc_low_ff,  crc_low_in;
   logic [31:0]          capture_ff,  capture_in;

   // output register
   logic        out_valid_ff, out_valid_in;
   status_type  out_status_ff, out_status_in;
   logic [7:0]  out_func_ff, out_func_in;
   logic [31:0] out_data_ff, out_data_in;

   logic        advance;   // output register free this cycle
   logic        go;        // input register item is processed
   logic        req_accept;
   logic        emit;

   assign advance    = !out_valid_ff || !rsp_stall;
   assign go         = in_valid_ff && advance;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   // ---------------- configuration writes ----------------
   always_comb begin
      min_addr_in = min_addr_ff;
      max_addr_in = max_addr_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_MIN_SLAVE_ADDRESS: min_addr_in = csr_write_data;
            CSR_MAX_SLAVE_ADDRESS: max_addr_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // ---------------- frame logic ----------------
   always_comb begin
      logic                 act;
      logic [POS_WIDTH-1:0] p;
      logic [POS_WIDTH-1:0] ln;
      logic [7:0]           fn;
      logic [15:0]          crc;
      logic [7:0]           lo;
      logic [31:0]          cap;
      logic [POS_WIDTH:0]   p_plus2;

      act = active_ff;
      p   = pos_ff;
      ln  = len_ff;
      fn  = func_ff;
      crc = crc_ff;
      lo  = crc_low_ff;
      cap = capture_ff;
      p_plus2 = '0;

      emit          = 1'b0;
      out_status_in = ST_NO_DATA;
      out_func_in   = func_ff;
      out_data_in   = 32'd0;

      active_in  = active_ff;
      pos_in     = pos_ff;
      len_in     = len_ff;
      func_in    = func_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      capture_in = capture_ff;

      if (go) begin
         if (in_start_ff) begin
            act = 1'b1;
            p   = '0;
            ln  = '0;
            fn  = 8'd0;
            crc = CRC_INIT;
            lo  = 8'd0;
            cap = 32'd0;
         end

         p_plus2 = {1'b0, p} + 10'd2;

         if (act) begin
            pos_in = p + 9'd1;
            if (p == POS_ADDRESS) begin
               crc = crc16_update(crc, in_byte_ff);
               if (in_byte_ff < min_addr_ff || in_byte_ff > max_addr_ff) begin
                  emit          = 1'b1;
                  out_status_in = ST_BAD_ADDRESS;
                  out_func_in   = 8'd0;
               end
            end else if (p == POS_FUNCTION) begin
               fn  = in_byte_ff;
               crc = crc16_update(crc, in_byte_ff);
               if (in_byte_ff != FC_READ_HOLDING && in_byte_ff != FC_WRITE_SINGLE &&
                   in_byte_ff != FC_WRITE_MULTIPLE) begin
                  emit          = 1'b1;
                  out_status_in = ST_BAD_FUNCTION;
                  out_func_in   = in_byte_ff;
               end
            end else if (p == POS_COUNT) begin
               ln  = {1'b0, in_byte_ff} + LEN_OVERHEAD;
               crc = crc16_update(crc, in_byte_ff);
               if ({1'b0, ln} > 10'(MAX_FRAME_BYTES)) begin
                  emit          = 1'b1;
                  out_status_in = ST_TOO_LONG;
                  out_func_in   = fn;
               end
            end else if (p_plus2 < {1'b0, ln}) begin
               crc = crc16_update(crc, in_byte_ff);
               if (p <= POS_LAST_DATA) begin
                  cap = {cap[23:0], in_byte_ff};
               end
            end else if (p_plus2 == {1'b0, ln}) begin
               lo = in_byte_ff;
            end else begin
               // trailing CRC high byte closes the frame
               emit        = 1'b1;
               out_func_in = fn;
               if ({in_byte_ff, lo} != crc) begin
                  out_status_in = ST_CRC_MISMATCH;
               end else if (fn == FC_READ_HOLDING && ln == LEN_FLOAT) begin
                  out_status_in = ST_FLOAT_OK;
                  out_data_in   = {cap[15:0], cap[31:16]};
               end else if (fn == FC_READ_HOLDING && ln == LEN_UINT) begin
                  out_status_in = ST_UINT_OK;
                  out_data_in   = {16'd0, cap[15:0]};
               end else begin
                  out_status_in = ST_NO_DATA;
               end
            end
         end

         active_in  = act && !emit;
         len_in     = ln;
         func_in    = fn;
         crc_in     = crc;
         crc_low_in = lo;
         capture_in = cap;
      end
   end

   // ---------------- handshake control ----------------
   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance) begin
         out_valid_in = go && emit;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_addr_ff  <= 8'd1;
         max_addr_ff  <= 8'd247;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         active_ff    <= 1'b0;
         pos_ff       <= '0;
         len_ff       <= '0;
         func_ff      <= 8'd0;
         crc_ff       <= CRC_INIT;
         crc_low_ff   <= 8'd0;
         capture_ff   <= 32'd0;
      end else begin
         min_addr_ff  <= min_addr_in;
         max_addr_ff  <= max_addr_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         active_ff    <= active_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         func_ff      <= func_in;
         crc_ff       <= crc_in;
         crc_low_ff   <= crc_low_in;
         capture_ff   <= capture_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_byte_ff  <= req_rx_byte;
         in_start_ff <= req_frame_start;
      end
      if (go && emit) begin
         out_status_ff <= out_status_in;
         out_func_ff   <= out_func_in;
         out_data_ff   <= out_data_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_function_code = out_func_ff;
   assign rsp_data_value    = out_data_ff;

`ifndef SYNTHESIS
   // a request is held back only when both registers are occupied
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("req_stall without full pipeline");

   // a float result only comes from a read-holding response
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FLOAT_OK) |-> rsp_function_code == FC_READ_HOLDING)
      else $error("float result with wrong function code");

   // bad address never carries a function code
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_BAD_ADDRESS) |-> rsp_function_code == 8'd0)
      else $error("bad address with function code");

   // only value results carry data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_FLOAT_OK && rsp_status != ST_UINT_OK)
         |-> rsp_data_value == 32'd0)
      else $error("data on a result without a value");
`endif

endmodule
